// ===== rtl/tsrp_pkg.sv =====
package tsrp_pkg;

	// Text bytes the parser reacts to
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_VT    = 8'h0B;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [1:0] FIELDS_MAX = 2'd3;

	typedef enum logic [1:0] {
		KIND_NAME   = 2'd0,
		KIND_RECORD = 2'd1,
		KIND_EXTRA  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Control from the line logic to the number accumulator
	typedef struct packed {
		logic step;     // a byte is consumed this cycle
		logic restart;  // block start: treat the held number as cleared
		logic drop;     // tab or newline: clear the number after this byte
	} num_ctrl_t;

	// Values derived from the number held before the current byte
	typedef struct packed {
		logic [31:0]        position;
		logic signed [63:0] length;
	} num_view_t;

endpackage

// ===== rtl/tsrp_in_if.sv =====
interface tsrp_in_if;
	import tsrp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       block_start;

	modport source (output valid, output text_byte, output block_start, input ready);
	modport sink   (input valid, input text_byte, input block_start, output ready);

endinterface

// ===== rtl/tsrp_out_if.sv =====
interface tsrp_out_if;
	import tsrp_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         name_byte;
	logic [31:0]        position;
	logic               position_valid;
	logic signed [63:0] template_length;
	logic [1:0]         fields_seen;
	logic [31:0]        record_index;

	modport source (
		output valid, output kind, output name_byte, output position,
		output position_valid, output template_length, output fields_seen,
		output record_index, input ready
	);
	modport sink (
		input valid, input kind, input name_byte, input position,
		input position_valid, input template_length, input fields_seen,
		input record_index, output ready
	);

endinterface

// ===== rtl/tsrp_number.sv =====
module tsrp_number
	import tsrp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  num_ctrl_t ctrl,
	input  logic [7:0] text_byte,
	output num_view_t view
);

	phase_t      phase_q, phase_e, phase_d;
	logic        neg_q, neg_e, neg_d;
	logic [63:0] mag_q, mag_e, mag_d;
	logic        ovf_q, ovf_e, ovf_d;

	logic        is_space, is_sign, is_digit;
	logic [67:0] prod;
	logic [31:0] low_bits;

	assign phase_e = ctrl.restart ? PH_SKIP : phase_q;
	assign neg_e   = ctrl.restart ? 1'b0    : neg_q;
	assign mag_e   = ctrl.restart ? 64'd0   : mag_q;
	assign ovf_e   = ctrl.restart ? 1'b0    : ovf_q;

	assign is_space = (text_byte == CHAR_SPACE) || (text_byte == CHAR_VT) ||
	                  (text_byte == CHAR_FF) || (text_byte == CHAR_CR);
	assign is_sign  = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);
	assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);

	// mag*10 + digit; anything above bit 63 means the 64-bit value overflowed
	assign prod = {1'b0, mag_e, 3'b000} + {3'b000, mag_e, 1'b0} + {64'd0, text_byte[3:0]};

	always_comb begin
		phase_d = phase_e;
		neg_d   = neg_e;
		mag_d   = mag_e;
		ovf_d   = ovf_e;
		if (phase_e == PH_SKIP && is_space) begin
			phase_d = phase_e;
		end else if (phase_e == PH_SKIP && is_sign) begin
			neg_d   = (text_byte == CHAR_MINUS);
			phase_d = PH_SIGN;
		end else if (phase_e == PH_DONE) begin
			phase_d = PH_DONE;
		end else if (!is_digit) begin
			phase_d = PH_DONE;
		end else begin
			phase_d = PH_DIGITS;
			if (!ovf_e) begin
				if (prod[67:64] != 4'd0) begin
					ovf_d = 1'b1;
				end else begin
					mag_d = prod[63:0];
				end
			end
		end
		if (ctrl.drop) begin
			phase_d = PH_SKIP;
			neg_d   = 1'b0;
			mag_d   = 64'd0;
			ovf_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= 64'd0;
			ovf_q   <= 1'b0;
		end else if (ctrl.step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			ovf_q   <= ovf_d;
		end
	end

	// Views used at a tab (position) and at a newline (length)
	assign low_bits = neg_e ? (32'd0 - mag_e[31:0]) : mag_e[31:0];

	always_comb begin
		view.position = ovf_e ? 32'hFFFF_FFFF : low_bits;
		if (neg_e) begin
			if (ovf_e || mag_e > 64'h8000_0000_0000_0000) begin
				view.length = 64'sh8000_0000_0000_0000;
			end else begin
				view.length = $signed(64'd0 - mag_e);
			end
		end else begin
			if (ovf_e || mag_e[63]) begin
				view.length = 64'sh7FFF_FFFF_FFFF_FFFF;
			end else begin
				view.length = $signed(mag_e);
			end
		end
	end

endmodule

// ===== rtl/tab_separated_record_parser.sv =====
// Streaming parser for text lines "name TAB position TAB length NEWLINE", one byte per
// beat on text. Each byte of the first segment of a line is echoed on rec as a name beat
// (kind 0); a newline produces a record beat (kind 1) carrying the 32-bit position latched
// at the second tab, the signed length parsed from the last segment and saturated to the
// 64-bit limits, the tab count and the line index within the block; every tab after the
// second produces an error beat (kind 2). Segments are read like strtoll: leading blanks
// skipped, optional sign, decimal digits up to the first other byte. block_start on a byte
// clears the line index and line state before that byte is used. Throughput is one byte
// per clock unless rec stalls: a byte is held in the input register, its result is decided
// by a single multiply-by-ten accumulate and lands in the output register that drives rec
// valid. The output register lets the next byte be taken while a result waits; a stall on
// rec holds only bytes that produce a result.
module tab_separated_record_parser
	import tsrp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tsrp_in_if.sink    text,
	tsrp_out_if.source rec
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       bstart_s1;

	// Line state
	logic [1:0]  fc_q, fc_e, fc_d;
	logic [31:0] hp_q, hp_e, hp_d;
	logic        hpv_q, hpv_e, hpv_d;
	logic [31:0] line_q, line_e, line_d;

	// Output register
	logic               out_valid_q;
	kind_t              kind_q;
	logic [7:0]         name_q;
	logic [31:0]        pos_q;
	logic               posv_q;
	logic signed [63:0] len_q;
	logic [1:0]         fseen_q;
	logic [31:0]        idx_q;

	logic      is_nl, is_tab, has_result, advance;
	num_ctrl_t nctrl;
	num_view_t nview;

	assign is_nl  = (byte_s1 == CHAR_NL);
	assign is_tab = (byte_s1 == CHAR_TAB);

	// Block start wipes the line before this byte is looked at
	assign fc_e   = bstart_s1 ? 2'd0  : fc_q;
	assign hp_e   = bstart_s1 ? 32'd0 : hp_q;
	assign hpv_e  = bstart_s1 ? 1'b0  : hpv_q;
	assign line_e = bstart_s1 ? 32'd0 : line_q;

	assign has_result = is_nl || (is_tab && fc_e >= 2'd2) || (!is_nl && !is_tab && fc_e == 2'd0);

	// Stage advances unless its result would collide with a stalled output beat
	assign advance    = valid_s1 && (!has_result || !out_valid_q || rec.ready);
	assign text.ready = !valid_s1 || advance;

	assign nctrl.step    = advance;
	assign nctrl.restart = bstart_s1;
	assign nctrl.drop    = is_nl || is_tab;

	tsrp_number u_number (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (nctrl),
		.text_byte (byte_s1),
		.view      (nview)
	);

	always_comb begin
		fc_d   = fc_e;
		hp_d   = hp_e;
		hpv_d  = hpv_e;
		line_d = line_e;
		if (is_nl) begin
			fc_d   = 2'd0;
			hp_d   = 32'd0;
			hpv_d  = 1'b0;
			line_d = line_e + 32'd1;
		end else if (is_tab) begin
			fc_d = (fc_e == FIELDS_MAX) ? FIELDS_MAX : fc_e + 2'd1;
			if (fc_e == 2'd1) begin
				hp_d  = nview.position;
				hpv_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1   <= text.text_byte;
			bstart_s1 <= text.block_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= 2'd0;
			hp_q   <= 32'd0;
			hpv_q  <= 1'b0;
			line_q <= 32'd0;
		end else if (advance) begin
			fc_q   <= fc_d;
			hp_q   <= hp_d;
			hpv_q  <= hpv_d;
			line_q <= line_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (rec.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; fields not meaningful for a kind are zero
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			idx_q <= line_e;
			if (is_nl) begin
				kind_q  <= KIND_RECORD;
				name_q  <= 8'd0;
				pos_q   <= hpv_e ? hp_e : 32'd0;
				posv_q  <= hpv_e;
				len_q   <= nview.length;
				fseen_q <= fc_e;
			end else if (is_tab) begin
				kind_q  <= KIND_EXTRA;
				name_q  <= 8'd0;
				pos_q   <= 32'd0;
				posv_q  <= 1'b0;
				len_q   <= 64'sd0;
				fseen_q <= fc_d;
			end else begin
				kind_q  <= KIND_NAME;
				name_q  <= byte_s1;
				pos_q   <= 32'd0;
				posv_q  <= 1'b0;
				len_q   <= 64'sd0;
				fseen_q <= 2'd0;
			end
		end
	end

	assign rec.valid           = out_valid_q;
	assign rec.kind            = kind_q;
	assign rec.name_byte       = name_q;
	assign rec.position        = pos_q;
	assign rec.position_valid  = posv_q;
	assign rec.template_length = len_q;
	assign rec.fields_seen     = fseen_q;
	assign rec.record_index    = idx_q;

	// Name beats only come from the first segment
	a_name_first_seg: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.kind == KIND_NAME |-> rec.fields_seen == 2'd0 && !rec.position_valid)
		else $error("name beat with tabs counted");

	// An extra-field beat always follows at least three tabs
	a_extra_three: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.kind == KIND_EXTRA |-> rec.fields_seen == FIELDS_MAX)
		else $error("extra-field beat with short tab count");

	// A record without a latched position reports zero position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rec.valid && rec.kind == KIND_RECORD && !rec.position_valid |-> rec.position == 32'd0)
		else $error("position without valid flag");

	// Line index steps by one on every newline
	a_line_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_nl |=> line_q == $past(line_e) + 32'd1)
		else $error("line index did not advance");

	// An empty input stage never refuses a byte
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> text.ready)
		else $error("input stalled while empty");

endmodule
